[rtl/xsb_pkg.sv]
// xsb_pkg: shared types, command codes and helpers for the XOR sprite blitter.
// No dependencies; every other file of the blitter but xsb_chan_if imports this package.
package xsb_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;
    localparam int SPRITE_BYTES      = 32;
    localparam int SLOT_W            = $clog2(SPRITE_BYTES);
    localparam int CFG_IDX_W         = 1;

    // command codes carried in the cmd field
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_DRAW  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HIRES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP  = 1'b1;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [7:0]        x_coord;
        logic [7:0]        y_coord;
        logic [3:0]        row_count;
        logic [SLOT_W-1:0] sprite_slot;
        logic [7:0]        sprite_byte;
    } t_in_item;

    typedef struct packed {
        logic collision;
        logic pixel_value;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic setup;
        logic load_store;
        logic clear;
        logic draw_wr;
        logic pix_cap;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic draw_last;
    } t_dp_stat;

    // Remainder of an 8-bit value by a screen size of at least 8:
    // the quotient fits in five bits, so five compare-and-subtract steps.
    function automatic logic [8:0] mod_screen(input logic [7:0] val, input logic [8:0] div);
        logic [12:0] rem;
        logic [12:0] step;
        rem = {5'd0, val};
        for (int k = 4; k >= 0; k--) begin
            step = {4'd0, div} << k;
            if (rem >= step) begin
                rem = rem - step;
            end
        end
        return rem[8:0];
    endfunction

endpackage

[rtl/xsb_chan_if.sv]
// xsb_chan_if: valid/ready channel carrying one payload beat of type T.
// Depends on nothing; the blitter binds it to types from xsb_pkg.
interface xsb_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/xsb_ctrl.sv]
// xsb_ctrl: command sequencer of the XOR sprite blitter.
// Depends on xsb_pkg; drives xsb_dp through t_dp_cmd and reads t_dp_stat.
module xsb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_in_cmd,
    input  logic              i_out_ready,
    input  xsb_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output xsb_pkg::t_dp_cmd  o_cmd
);
    import xsb_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_LOAD, S_DSET, S_RSET, S_RD, S_WR, S_PRD, S_PIX, S_CLR, S_DONE
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd cmd;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        cmd         = '0;
        case (r_state)
            S_INIT: begin
                cmd.clear = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    case (i_in_cmd)
                        CMD_LOAD:  n_state = S_LOAD;
                        CMD_DRAW:  n_state = S_DSET;
                        CMD_CLEAR: n_state = S_CLR;
                        CMD_READ:  n_state = S_RSET;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_LOAD: begin
                cmd.load_store = 1'b1;
                n_state        = S_DONE;
            end
            S_DSET: begin
                cmd.setup = 1'b1;
                n_state   = S_RD;
            end
            S_RSET: begin
                cmd.setup = 1'b1;
                n_state   = S_PRD;
            end
            S_RD: n_state = S_WR;
            S_WR: begin
                cmd.draw_wr = 1'b1;
                n_state     = i_stat.draw_last ? S_DONE : S_RD;
            end
            S_PRD: n_state = S_PIX;
            S_PIX: begin
                cmd.pix_cap = 1'b1;
                n_state     = S_DONE;
            end
            S_CLR: begin
                cmd.clear = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

[rtl/xsb_dp.sv]
// xsb_dp: frame buffer (one row per word), sprite store, coordinate and
// row counters and the XOR lane logic of the blitter. Depends on xsb_pkg.
module xsb_dp #(
    parameter int SCREEN_WIDTH  = xsb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = xsb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [xsb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic                              i_cfg_data,
    input  xsb_pkg::t_in_item                 i_item,
    input  xsb_pkg::t_dp_cmd                  i_cmd,
    output xsb_pkg::t_dp_stat                 o_stat,
    output xsb_pkg::t_out_item                o_result
);
    import xsb_pkg::*;

    localparam int COL_W = $clog2(SCREEN_WIDTH);
    localparam int ROW_W = $clog2(SCREEN_HEIGHT);
    localparam logic [8:0] W_HI = 9'(SCREEN_WIDTH);
    localparam logic [8:0] W_LO = 9'(SCREEN_WIDTH / 2);
    localparam logic [8:0] H_HI = 9'(SCREEN_HEIGHT);
    localparam logic [8:0] H_LO = 9'(SCREEN_HEIGHT / 2);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SCREEN_HEIGHT - 1);

    logic [SCREEN_WIDTH-1:0] fb_mem [SCREEN_HEIGHT];
    logic [7:0]              ss_mem [SPRITE_BYTES];

    logic                    r_hires, r_wrap;
    logic [ROW_W-1:0]        r_clr_row;
    t_in_item                r_item;
    logic [COL_W-1:0]        r_px;
    logic [ROW_W-1:0]        r_ty;
    logic [4:0]              r_rows;
    logic                    r_half;
    logic [SLOT_W-1:0]       r_sidx;
    logic                    r_hit, r_pix;
    logic [SCREEN_WIDTH-1:0] r_fb_rd;
    logic [7:0]              r_ss_rd;
    t_out_item               r_out;

    logic [8:0]              act_w, act_h, base;
    logic [SCREEN_WIDTH-1:0] mask;
    logic                    row_end, draw_last;
    logic                    fb_we;
    logic [ROW_W-1:0]        fb_wa;
    logic [SCREEN_WIDTH-1:0] fb_wd;

    assign act_w = r_hires ? W_HI : W_LO;
    assign act_h = r_hires ? H_HI : H_LO;

    // left byte starts at px, right byte of a wide sprite eight further on
    always_comb begin
        base = 9'(r_px) + (r_half ? 9'd8 : 9'd0);
        if (r_wrap && base >= act_w) begin
            base = base - act_w;
        end
    end

    // one lane per column: which sprite bit, if any, lands here
    always_comb begin
        logic [9:0] col;
        logic [9:0] offs;
        logic [2:0] bit_sel;
        mask = '0;
        for (int i = 0; i < SCREEN_WIDTH; i++) begin
            col = 10'(i);
            if (col >= {1'b0, base}) begin
                offs = col - {1'b0, base};
            end else if (r_wrap) begin
                offs = col + {1'b0, act_w} - {1'b0, base};
            end else begin
                offs = 10'h3FF;
            end
            bit_sel = 3'd7 - offs[2:0];
            mask[i] = (col < {1'b0, act_w}) && (offs < 10'd8) && r_ss_rd[bit_sel];
        end
    end

    assign row_end   = !((r_item.row_count == 4'd0) && !r_half);
    assign draw_last = row_end &&
                       ((r_rows == 5'd1) || (!r_wrap && ({1'b0, 8'(r_ty)} == act_h - 9'd1)));

    assign o_stat.draw_last = draw_last;
    assign o_stat.clr_last  = (r_clr_row == ROW_LAST);

    assign fb_we = i_cmd.clear || i_cmd.draw_wr;
    assign fb_wa = i_cmd.clear ? r_clr_row : r_ty;
    assign fb_wd = i_cmd.clear ? '0 : (r_fb_rd ^ mask);

    // memories: one write port each, registered read
    always_ff @(posedge i_clk) begin
        if (fb_we) begin
            fb_mem[fb_wa] <= fb_wd;
        end
        r_fb_rd <= fb_mem[r_ty];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_store) begin
            ss_mem[r_item.sprite_slot] <= r_item.sprite_byte;
        end
        r_ss_rd <= ss_mem[r_sidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hires   <= 1'b0;
            r_wrap    <= 1'b0;
            r_clr_row <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HIRES: r_hires <= i_cfg_data;
                    CFG_WRAP:  r_wrap  <= i_cfg_data;
                    default:   ;
                endcase
            end
            if (i_cmd.clear) begin
                r_clr_row <= (r_clr_row == ROW_LAST) ? '0 : r_clr_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
            r_hit  <= 1'b0;
            r_pix  <= 1'b0;
        end
        if (i_cmd.setup) begin
            r_px   <= COL_W'(mod_screen(r_item.x_coord, act_w));
            r_ty   <= ROW_W'(mod_screen(r_item.y_coord, act_h));
            r_rows <= (r_item.row_count == 4'd0) ? 5'd16 : {1'b0, r_item.row_count};
            r_half <= 1'b0;
            r_sidx <= '0;
        end
        if (i_cmd.draw_wr) begin
            r_hit  <= r_hit | (|(mask & r_fb_rd));
            r_sidx <= r_sidx + 1'b1;
            if (!row_end) begin
                r_half <= 1'b1;
            end else begin
                r_half <= 1'b0;
                r_rows <= r_rows - 5'd1;
                r_ty   <= ({1'b0, 8'(r_ty)} + 9'd1 == act_h) ? '0 : r_ty + 1'b1;
            end
        end
        if (i_cmd.pix_cap) begin
            r_pix <= r_fb_rd[r_px];
        end
        if (i_cmd.out_load) begin
            r_out.collision   <= r_hit;
            r_out.pixel_value <= r_pix;
        end
    end

    assign o_result = r_out;

endmodule

[rtl/xor_sprite_blitter.sv]
// xor_sprite_blitter: top level, one-bit frame buffer with XOR sprite drawing.
// Depends on xsb_pkg, xsb_chan_if, xsb_ctrl and xsb_dp.
//
//   channel    | dir | payload     | beat
//   -----------+-----+-------------+--------------------------------------------
//   i_in_ch    | in  | t_in_item   | one command: load, draw, clear or read
//   o_out_ch   | out | t_out_item  | one result per command (collision, pixel)
//   i_cfg_*    | in  | 1-bit reg   | write of high_resolution (0) / wrap_mode (1)
//
// A draw walks B sprite bytes (N, or 32 for the 16x16 sprite, fewer when the
// bottom edge clips). Each byte is a read-modify-write of one frame buffer
// row: the row is read first, then XORed with the sprite byte and written back.
// After reset a clearing pass zeroes every row of the frame buffer;
// no beat is accepted during it, configuration writes are taken throughout.
// The result sits in an output register: a new command is accepted while it
// waits, and the block only holds in its final state if the previous result
// has still not been taken.
module xor_sprite_blitter #(
    parameter int SCREEN_WIDTH  = xsb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = xsb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [xsb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic                          i_cfg_data,
    xsb_chan_if.sink                      i_in_ch,
    xsb_chan_if.source                    o_out_ch
);
    import xsb_pkg::*;

    t_dp_cmd   dp_cmd;
    t_dp_stat  dp_stat;
    t_in_item  in_item;
    t_out_item out_item;
    logic      in_ready;
    logic      out_valid;

    // hold the incoming beat as the package type
    assign in_item = i_in_ch.data;

    // sequencer: owns handshakes and the order of datapath steps
    xsb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .i_in_cmd    (in_item.cmd),
        .i_out_ready (o_out_ch.ready),
        .i_stat      (dp_stat),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (dp_cmd)
    );

    // datapath: frame buffer rows, sprite store, counters and lane XOR
    xsb_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (in_item),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_result   (out_item)
    );

    assign i_in_ch.ready  = in_ready;
    assign o_out_ch.valid = out_valid;
    assign o_out_ch.data  = out_item;

endmodule

[test/xsb_result_check.sv]
// xsb_result_check: watches the command, result and register ports of the blitter,
// predicts every result beat and compares it. Depends on xsb_pkg only.
module xsb_result_check #(
    parameter int SCREEN_WIDTH  = xsb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = xsb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [xsb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic                          i_cfg_data,
    input  logic                          i_cmd_valid,
    input  logic                          i_cmd_ready,
    input  xsb_pkg::t_in_item             i_cmd,
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    input  xsb_pkg::t_out_item            i_res,
    output int                            o_mismatches,
    output int                            o_outstanding
);
    import xsb_pkg::*;

    logic       pixels [SCREEN_WIDTH*SCREEN_HEIGHT];
    logic [7:0] glyph [SPRITE_BYTES];
    logic       hires;
    logic       wrap;
    t_out_item  expected_q [$];

    // XOR one sprite byte into a row; report whether a lit pixel went dark.
    function automatic logic xor_glyph_byte(int x, int y, logic [7:0] bits, int w);
        logic hit;
        int   col;
        hit = 1'b0;
        col = x;
        if (bits == 8'd0) return 1'b0;
        if (wrap) col = col % w;
        else if (col >= w) return 1'b0;
        for (int b = 0; b < 8; b++) begin
            if (bits[7-b]) begin
                pixels[y*SCREEN_WIDTH+col] ^= 1'b1;
                if (pixels[y*SCREEN_WIDTH+col] == 1'b0) hit = 1'b1;
            end
            if (!wrap && col == w - 1) return hit;
            col = (col + 1) % w;
        end
        return hit;
    endfunction

    function automatic t_out_item predict_result(t_in_item c);
        int        w;
        int        h;
        int        px;
        int        ty;
        int        rows;
        t_out_item r;
        r = '0;
        w = hires ? SCREEN_WIDTH : SCREEN_WIDTH / 2;
        h = hires ? SCREEN_HEIGHT : SCREEN_HEIGHT / 2;
        case (c.cmd)
            CMD_LOAD: begin
                glyph[c.sprite_slot] = c.sprite_byte;
            end
            CMD_DRAW: begin
                px   = int'(c.x_coord) % w;
                ty   = int'(c.y_coord) % h;
                rows = (c.row_count == 4'd0) ? 16 : int'(c.row_count);
                for (int t = 0; t < rows; t++) begin
                    if (c.row_count == 4'd0) begin
                        r.collision = r.collision | xor_glyph_byte(px, ty, glyph[2*t], w);
                        r.collision = r.collision | xor_glyph_byte(px + 8, ty, glyph[2*t+1], w);
                    end else begin
                        r.collision = r.collision | xor_glyph_byte(px, ty, glyph[t], w);
                    end
                    if (!wrap && ty == h - 1) break;
                    ty = (ty + 1) % h;
                end
            end
            CMD_CLEAR: begin
                foreach (pixels[i]) pixels[i] = 1'b0;
            end
            default: begin
                r.pixel_value = pixels[(int'(c.y_coord) % h) * SCREEN_WIDTH
                                       + int'(c.x_coord) % w];
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            expected_q.delete();
            foreach (pixels[i]) pixels[i] = 1'b0;
            hires        = 1'b0;
            wrap         = 1'b0;
            o_mismatches = 0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_q.size() == 0) begin
                    if (o_mismatches < 10)
                        $display("result beat with nothing expected: collision=%0b pixel=%0b",
                                 i_res.collision, i_res.pixel_value);
                    o_mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    if (want.collision !== i_res.collision
                        || want.pixel_value !== i_res.pixel_value) begin
                        if (o_mismatches < 10)
                            $display("result mismatch: expected collision=%0b pixel=%0b,",
                                     want.collision, want.pixel_value,
                                     " got collision=%0b pixel=%0b",
                                     i_res.collision, i_res.pixel_value);
                        o_mismatches++;
                    end
                end
            end
            if (i_cmd_valid && i_cmd_ready) expected_q.push_back(predict_result(i_cmd));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HIRES: hires = i_cfg_data;
                    CFG_WRAP:  wrap  = i_cfg_data;
                    default:   ;
                endcase
            end
        end
        o_outstanding = expected_q.size();
    end

endmodule

[test/xor_sprite_blitter_test.sv]
// xor_sprite_blitter_test: stimulus and verdict for the XOR sprite blitter.
// Depends on xsb_pkg, xsb_chan_if, xor_sprite_blitter and xsb_result_check.
module xor_sprite_blitter_test;
    import xsb_pkg::*;

    // Receiver hold-off: after these many result beats, drop ready for a long
    // stretch so the output register fills and the command port stalls.
    localparam int HOLD_AT_A = 150;
    localparam int HOLD_AT_B = 700;
    localparam int HOLD_LEN  = 400;
    localparam int PHASES    = 8;
    localparam int PHASE_LEN = 135;
    // slowest command is a 16x16 draw, which walks all 32 sprite bytes
    localparam int TAIL_CYCLES = 80;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic                 i_cfg_data;

    xsb_chan_if #(.T(t_in_item))  in_ch ();
    xsb_chan_if #(.T(t_out_item)) out_ch ();

    int mismatches;
    int outstanding;

    // sender and receiver bookkeeping
    int         sent;
    int         beats_taken;
    logic       cur_hires;
    logic [7:0] last_x;
    logic [7:0] last_y;

    xor_sprite_blitter uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch)
    );

    xsb_result_check check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd_valid   (in_ch.valid),
        .i_cmd_ready   (in_ch.ready),
        .i_cmd         (in_ch.data),
        .i_res_valid   (out_ch.valid),
        .i_res_ready   (out_ch.ready),
        .i_res         (out_ch.data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Hard limit: far beyond the slowest legal run.
    initial begin
        #24000000;
        $display("xor_sprite_blitter_test NOT OK");
        $finish;
    end

    // Offer one command beat. Called at a falling edge, returns at a falling
    // edge with valid still high, so a back-to-back beat needs no second drive.
    task automatic push_command(t_in_item c);
        int gap;
        // every fifth stretch of 50 beats runs with no idling at all
        gap = ((sent / 50) % 5 == 2) ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.data  <= c;
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        sent++;
        @(negedge i_clk);
    endtask

    task automatic issue(logic [1:0] cmd, logic [7:0] x, logic [7:0] y,
                         logic [3:0] n, logic [SLOT_W-1:0] slot, logic [7:0] bits);
        t_in_item c;
        c.cmd         = cmd;
        c.x_coord     = x;
        c.y_coord     = y;
        c.row_count   = n;
        c.sprite_slot = slot;
        c.sprite_byte = bits;
        push_command(c);
    endtask

    // Drop valid and hold until every result beat is back and the block is idle.
    task automatic settle();
        in_ch.valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write both registers on consecutive edges; called at a falling edge.
    task automatic write_settings(logic hires, logic wrap);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_HIRES;
        i_cfg_data <= hires;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_WRAP;
        i_cfg_data <= wrap;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_hires = hires;
    endtask

    // Mostly well-formed traffic: draws near the edges or anywhere, reads that
    // probe the spot just drawn, occasional loads and clears. Unused fields
    // carry random noise.
    function automatic t_in_item random_command();
        t_in_item c;
        int       w;
        int       h;
        int       roll;
        int       sel;
        w = cur_hires ? SCREEN_WIDTH_DEF : SCREEN_WIDTH_DEF / 2;
        h = cur_hires ? SCREEN_HEIGHT_DEF : SCREEN_HEIGHT_DEF / 2;
        c.x_coord     = 8'($urandom_range(0, 255));
        c.y_coord     = 8'($urandom_range(0, 255));
        c.row_count   = 4'($urandom_range(0, 15));
        c.sprite_slot = SLOT_W'($urandom_range(0, SPRITE_BYTES - 1));
        c.sprite_byte = 8'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            c.cmd = CMD_LOAD;
            sel = $urandom_range(0, 9);
            if (sel == 0) c.sprite_byte = 8'h00;
            else if (sel == 1) c.sprite_byte = 8'hFF;
        end else if (roll < 52) begin
            c.cmd = CMD_DRAW;
            if ($urandom_range(0, 6) == 0) c.row_count = 4'd0;
            sel = $urandom_range(0, 2);
            if (sel == 0) begin
                // hug the right and bottom edges to exercise clip and wrap
                c.x_coord = 8'(w - 1 - $urandom_range(0, 10));
                c.y_coord = 8'(h - 1 - $urandom_range(0, 12));
            end else if (sel == 1) begin
                c.x_coord = last_x + 8'($urandom_range(0, 6));
                c.y_coord = last_y + 8'($urandom_range(0, 6));
            end
            last_x = c.x_coord;
            last_y = c.y_coord;
        end else if (roll < 56) begin
            c.cmd = CMD_CLEAR;
        end else begin
            c.cmd = CMD_READ;
            if ($urandom_range(0, 9) < 7) begin
                c.x_coord = last_x + 8'($urandom_range(0, 17));
                c.y_coord = last_y + 8'($urandom_range(0, 17));
            end
        end
        return c;
    endfunction

    // Receiver: random gaps per beat, stretches with no gaps, and two long hold-offs.
    initial begin : receiver
        int gap;
        out_ch.ready = 1'b0;
        beats_taken  = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = ((beats_taken / 64) % 4 == 1) ? 0 : $urandom_range(0, 7);
            if (beats_taken == HOLD_AT_A || beats_taken == HOLD_AT_B) gap = HOLD_LEN;
            if (gap != 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            beats_taken++;
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        logic hires;
        logic wrap;
        // drive every input to a known value from time zero
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_HIRES;
        i_cfg_data  = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        sent        = 0;
        cur_hires   = 1'b0;
        last_x      = 8'd0;
        last_y      = 8'd0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // registers are taken during the post-reset clearing pass
        write_settings(1'b0, 1'b0);

        // ---- directed part: low resolution, clipped ----
        issue(CMD_LOAD, 8'd0, 8'd0, 4'd0, 5'd0, 8'hFF);
        issue(CMD_LOAD, 8'd0, 8'd0, 4'd0, 5'd1, 8'h81);
        issue(CMD_LOAD, 8'd0, 8'd0, 4'd0, 5'd2, 8'h00);    // zero byte draws nothing
        issue(CMD_LOAD, 8'd0, 8'd0, 4'd0, 5'd3, 8'h80);
        issue(CMD_DRAW, 8'd0, 8'd0, 4'd1, 5'd0, 8'h00);
        issue(CMD_READ, 8'd7, 8'd0, 4'd0, 5'd0, 8'h00);
        issue(CMD_DRAW, 8'd0, 8'd0, 4'd1, 5'd0, 8'h00);    // same spot again: collision
        issue(CMD_READ, 8'd0, 8'd0, 4'd0, 5'd0, 8'h00);
        // clip past the right edge and the bottom row
        issue(CMD_DRAW, 8'd60, 8'd30, 4'd4, 5'd0, 8'h00);
        issue(CMD_READ, 8'd60, 8'd31, 4'd0, 5'd0, 8'h00);
        // coordinates reduced to the active size
        issue(CMD_DRAW, 8'd255, 8'd255, 4'd3, 5'd0, 8'h00);
        issue(CMD_READ, 8'd255, 8'd255, 4'd0, 5'd0, 8'h00);
        issue(CMD_DRAW, 8'd8, 8'd4, 4'd3, 5'd0, 8'h00);
        issue(CMD_CLEAR, 8'd0, 8'd0, 4'd0, 5'd0, 8'h00);
        issue(CMD_READ, 8'd0, 8'd0, 4'd0, 5'd0, 8'h00);

        // ---- directed part: high resolution, wrapping ----
        settle();
        write_settings(1'b1, 1'b1);
        issue(CMD_DRAW, 8'd124, 8'd62, 4'd4, 5'd0, 8'h00);
        issue(CMD_READ, 8'd0, 8'd62, 4'd0, 5'd0, 8'h00);
        issue(CMD_READ, 8'd127, 8'd63, 4'd0, 5'd0, 8'h00);
        issue(CMD_DRAW, 8'd255, 8'd255, 4'd2, 5'd0, 8'h00);
        issue(CMD_READ, 8'd1, 8'd0, 4'd0, 5'd0, 8'h00);

        // resolution change with no clear: pixels keep their positions
        settle();
        write_settings(1'b0, 1'b0);
        issue(CMD_READ, 8'd3, 8'd62, 4'd0, 5'd0, 8'h00);
        issue(CMD_DRAW, 8'd0, 8'd31, 4'd4, 5'd0, 8'h00);
        issue(CMD_CLEAR, 8'd0, 8'd0, 4'd0, 5'd0, 8'h00);

        // ---- random part: fill the whole store, then mixed traffic ----
        for (int s = 0; s < SPRITE_BYTES; s++)
            issue(CMD_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  4'($urandom_range(0, 15)), SLOT_W'(s), 8'($urandom_range(0, 255)));
        issue(CMD_DRAW, 8'd60, 8'd20, 4'd0, 5'd0, 8'h00);  // 16x16 sprite, clipped
        issue(CMD_DRAW, 8'd10, 8'd10, 4'd15, 5'd0, 8'h00);

        for (int ph = 0; ph < PHASES; ph++) begin
            // fixed corners of the register space first, then random settings
            if (ph < 4) begin
                hires = (ph < 2);
                wrap  = (ph % 2 == 0);
            end else begin
                hires = 1'($urandom_range(0, 1));
                wrap  = 1'($urandom_range(0, 1));
            end
            settle();
            write_settings(hires, wrap);
            if ($urandom_range(0, 1) == 1)
                issue(CMD_CLEAR, 8'd0, 8'd0, 4'd0, 5'd0, 8'h00);
            repeat (PHASE_LEN) push_command(random_command());
        end

        // drain, then let the slowest command's worth of cycles pass
        settle();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("xor_sprite_blitter_test OK");
        else
            $display("xor_sprite_blitter_test NOT OK");
        $finish;
    end

endmodule

[xor_sprite_blitter.f]
rtl/xsb_pkg.sv
rtl/xsb_chan_if.sv
rtl/xsb_ctrl.sv
rtl/xsb_dp.sv
rtl/xor_sprite_blitter.sv
test/xsb_result_check.sv
test/xor_sprite_blitter_test.sv
